/* sv/dht_pkg.sv */
// ============================================================================
// dht_pkg
// Shared types and constants of the double hashing key table.
// ============================================================================
`default_nettype none

package dht_pkg;

  localparam int KEY_W    = 31;
  localparam int SLOT_W   = 4;
  localparam int STATUS_W = 2;

  // Widest slot number over the supported table sizes (up to 1024 slots).
  localparam int HASH_W = 10;

  // The front end folds the key into both remainders a few bits per cycle.
  localparam int DIGIT_BITS = 4;
  localparam int CALC_STEPS = 8;
  localparam int SHIFT_W    = DIGIT_BITS * CALC_STEPS;

  localparam logic FN_INSERT = 1'b0;
  localparam logic FN_SEARCH = 1'b1;

  localparam logic [STATUS_W-1:0] ST_OK   = 2'd0;
  localparam logic [STATUS_W-1:0] ST_MISS = 2'd1;
  localparam logic [STATUS_W-1:0] ST_ZERO = 2'd2;

  typedef struct packed {
    logic             func;
    logic [KEY_W-1:0] key;
  } dht_req_t;

  typedef struct packed {
    logic [SLOT_W-1:0]   slot_index;
    logic [STATUS_W-1:0] status;
  } dht_rsp_t;

  // One classified request as it waits between front and back.
  typedef struct packed {
    logic              zero;
    logic              func;
    logic [KEY_W-1:0]  key;
    logic [HASH_W-1:0] h1;
    logic [HASH_W-1:0] h2;
  } dht_job_t;

endpackage

`default_nettype wire

/* sv/dht_front.sv */
// ============================================================================
// dht_front
// Takes a request, works out the home slot and the probe step from the key,
// and pushes the classified job into the queue.
// ============================================================================
`default_nettype none

module dht_front #(
  parameter int TABLE_SIZE  = 16,
  parameter int PROBE_PRIME = 13
) (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              accept,
  input  wire dht_pkg::dht_req_t req,
  output      logic              active,
  output      logic              push,
  output      dht_pkg::dht_job_t job,
  input  wire logic              full
);
  import dht_pkg::*;

  localparam int IDX_W = $clog2(TABLE_SIZE);
  localparam int PW    = $clog2(PROBE_PRIME);
  localparam int CNT_W = $clog2(CALC_STEPS);

  localparam logic [IDX_W:0]   T_C       = (IDX_W+1)'(TABLE_SIZE);
  localparam logic [PW:0]      P_C       = (PW+1)'(PROBE_PRIME);
  localparam logic [HASH_W:0]  T_WIDE    = (HASH_W+1)'(TABLE_SIZE);
  localparam logic [HASH_W:0]  P_WIDE    = (HASH_W+1)'(PROBE_PRIME);
  localparam logic [CNT_W-1:0] CNT_LAST  = CNT_W'(CALC_STEPS-1);

  localparam logic [1:0] F_IDLE = 2'd0;
  localparam logic [1:0] F_CALC = 2'd1;
  localparam logic [1:0] F_PUSH = 2'd2;

  logic [1:0]         state;
  logic [CNT_W-1:0]   cnt;
  logic [SHIFT_W-1:0] sh;
  logic [IDX_W-1:0]   r1;
  logic [PW-1:0]      r2;
  logic               zero;
  logic               func;
  logic [KEY_W-1:0]   key;

  logic [IDX_W-1:0]   r1_next;
  logic [PW-1:0]      r2_next;
  logic [HASH_W:0]    step_wide;

  // Remainders by a constant taken MSB first: r = (2r + bit) mod M, where one
  // conditional subtract suffices because 2r + bit stays below 2M.
  always_comb begin
    logic [IDX_W:0] t1;
    logic [PW:0]    t2;
    r1_next = r1;
    r2_next = r2;
    for (int i = 0; i < DIGIT_BITS; i++) begin
      t1 = {r1_next, sh[SHIFT_W-1-i]};
      if (t1 >= T_C) t1 = t1 - T_C;
      r1_next = t1[IDX_W-1:0];
      t2 = {r2_next, sh[SHIFT_W-1-i]};
      if (t2 >= P_C) t2 = t2 - P_C;
      r2_next = t2[PW-1:0];
    end
  end

  // The prime sits below the table size, so one subtract folds the step.
  always_comb begin
    step_wide = P_WIDE - (HASH_W+1)'(r2);
    if (step_wide >= T_WIDE) step_wide = step_wide - T_WIDE;
  end

  always_comb begin
    job.zero = zero;
    job.func = func;
    job.key  = key;
    job.h1   = HASH_W'(r1);
    job.h2   = step_wide[HASH_W-1:0];
  end

  assign push   = (state == F_PUSH) && !full;
  assign active = (state != F_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= F_IDLE;
      cnt   <= '0;
    end else begin
      unique case (state)
        F_IDLE: begin
          if (accept) begin
            func <= req.func;
            key  <= req.key;
            zero <= (req.key == '0);
            sh   <= SHIFT_W'(req.key);
            r1   <= '0;
            r2   <= '0;
            cnt  <= '0;
            state <= (req.key == '0) ? F_PUSH : F_CALC;
          end
        end
        F_CALC: begin
          r1  <= r1_next;
          r2  <= r2_next;
          sh  <= sh << DIGIT_BITS;
          cnt <= cnt + 1'b1;
          if (cnt == CNT_LAST) state <= F_PUSH;
        end
        F_PUSH: begin
          if (!full) state <= F_IDLE;
        end
        default: state <= F_IDLE;
      endcase
    end
  end

endmodule

`default_nettype wire

/* sv/dht_queue.sv */
// ============================================================================
// dht_queue
// Two-entry job queue between the hash front end and the probe engine.
// ============================================================================
`default_nettype none

module dht_queue (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              push,
  input  wire dht_pkg::dht_job_t push_job,
  output      logic              full,
  input  wire logic              pop,
  output      dht_pkg::dht_job_t head,
  output      logic              empty
);
  import dht_pkg::*;

  dht_job_t   entries [2];
  logic       wp;
  logic       rp;
  logic [1:0] count;

  assign full  = (count == 2'd2);
  assign empty = (count == 2'd0);
  assign head  = entries[rp];

  always_ff @(posedge clk) begin
    if (push) entries[wp] <= push_job;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wp    <= 1'b0;
      rp    <= 1'b0;
      count <= 2'd0;
    end else begin
      if (push) wp <= ~wp;
      if (pop)  rp <= ~rp;
      unique case ({push, pop})
        2'b10:   count <= count + 2'd1;
        2'b01:   count <= count - 2'd1;
        default: count <= count;
      endcase
    end
  end

endmodule

`default_nettype wire

/* sv/dht_back.sv */
// ============================================================================
// dht_back
// Probe engine: owns the key table, walks the probe sequence one slot per
// cycle and issues one result per job.
// ============================================================================
`default_nettype none

module dht_back #(
  parameter int TABLE_SIZE  = 16
) (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire dht_pkg::dht_job_t head,
  input  wire logic              empty,
  output      logic              pop,
  output      logic              clearing,
  output      logic              done,
  output      dht_pkg::dht_rsp_t rsp
);
  import dht_pkg::*;

  localparam int IDX_W = $clog2(TABLE_SIZE);
  localparam int SW    = (IDX_W > SLOT_W) ? IDX_W : SLOT_W;

  localparam logic [IDX_W:0]   T_C  = (IDX_W+1)'(TABLE_SIZE);
  localparam logic [IDX_W-1:0] LAST = IDX_W'(TABLE_SIZE-1);

  localparam logic [1:0] B_CLEAR = 2'd0;
  localparam logic [1:0] B_IDLE  = 2'd1;
  localparam logic [1:0] B_PROBE = 2'd2;

  logic [KEY_W-1:0] mem [TABLE_SIZE];
  logic [KEY_W-1:0] rd_data;

  logic [1:0]       state, state_next;
  logic [IDX_W-1:0] clr_cnt, clr_cnt_next;
  logic [IDX_W-1:0] pos, pos_next;
  logic [IDX_W-1:0] step, step_next;
  logic [IDX_W-1:0] tries, tries_next;
  logic [KEY_W-1:0] key, key_next;
  logic             func, func_next;
  logic             done_next;
  dht_rsp_t         rsp_next;

  logic             we;
  logic [IDX_W-1:0] wa;
  logic [KEY_W-1:0] wd;
  logic [IDX_W-1:0] ra;
  logic [IDX_W:0]   sum;
  logic [IDX_W-1:0] pos_adv;
  logic [SW-1:0]    pos_w;

  always_ff @(posedge clk) begin
    if (we) mem[wa] <= wd;
    rd_data <= mem[ra];
  end

  always_comb begin
    sum = {1'b0, pos} + {1'b0, step};
    if (sum >= T_C) sum = sum - T_C;
    pos_adv = sum[IDX_W-1:0];
    pos_w   = SW'(pos);
  end

  always_comb begin
    state_next   = state;
    clr_cnt_next = clr_cnt;
    pos_next     = pos;
    step_next    = step;
    tries_next   = tries;
    key_next     = key;
    func_next    = func;
    done_next    = 1'b0;
    rsp_next     = rsp;
    we           = 1'b0;
    wa           = pos;
    wd           = key;
    ra           = pos;
    pop          = 1'b0;

    unique case (state)
      B_CLEAR: begin
        we           = 1'b1;
        wa           = clr_cnt;
        wd           = '0;
        clr_cnt_next = clr_cnt + 1'b1;
        if (clr_cnt == LAST) state_next = B_IDLE;
      end
      B_IDLE: begin
        if (!empty) begin
          pop = 1'b1;
          if (head.zero) begin
            done_next           = 1'b1;
            rsp_next.slot_index = '0;
            rsp_next.status     = ST_ZERO;
          end else begin
            pos_next   = head.h1[IDX_W-1:0];
            step_next  = head.h2[IDX_W-1:0];
            key_next   = head.key;
            func_next  = head.func;
            tries_next = '0;
            ra         = head.h1[IDX_W-1:0];
            state_next = B_PROBE;
          end
        end
      end
      B_PROBE: begin
        // rd_data holds the slot at pos; the next slot is read meanwhile.
        priority if (func == FN_INSERT && rd_data == '0) begin
          we                  = 1'b1;
          done_next           = 1'b1;
          rsp_next.slot_index = pos_w[SLOT_W-1:0];
          rsp_next.status     = ST_OK;
          state_next          = B_IDLE;
        end else if (func == FN_SEARCH && rd_data == key) begin
          done_next           = 1'b1;
          rsp_next.slot_index = pos_w[SLOT_W-1:0];
          rsp_next.status     = ST_OK;
          state_next          = B_IDLE;
        end else if ((func == FN_SEARCH && rd_data == '0) || tries == LAST) begin
          done_next           = 1'b1;
          rsp_next.slot_index = '0;
          rsp_next.status     = ST_MISS;
          state_next          = B_IDLE;
        end else begin
          pos_next   = pos_adv;
          tries_next = tries + 1'b1;
          ra         = pos_adv;
        end
      end
      default: state_next = B_CLEAR;
    endcase
  end

  assign clearing = (state == B_CLEAR);

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= B_CLEAR;
      clr_cnt <= '0;
      done    <= 1'b0;
    end else begin
      state   <= state_next;
      clr_cnt <= clr_cnt_next;
      done    <= done_next;
    end
  end

  always_ff @(posedge clk) begin
    pos   <= pos_next;
    step  <= step_next;
    tries <= tries_next;
    key   <= key_next;
    func  <= func_next;
    rsp   <= rsp_next;
  end

endmodule

`default_nettype wire

/* sv/double_hash_table_core.sv */
// ============================================================================
// double_hash_table_core
// Open-addressing key table with double hashing: insert and search requests.
// ============================================================================
//
//   Port group   Direction  Handshake               Payload
//   request      in         start && !busy          req  (dht_req_t: func, key)
//   result       out        done, one cycle         rsp  (dht_rsp_t: slot_index, status)
//
// After reset the key table is cleared with busy high.
// The front end works out the two remainders of a nonzero key
// (DIGIT_BITS key bits a cycle), then queues the job,
// held with busy high while the queue is full.
// The probe engine starts a job from its idle state, then takes one cycle per probe
// over the single table read port; a zero key is answered without a probe.
// ============================================================================
`default_nettype none

module double_hash_table_core #(
  parameter int TABLE_SIZE  = 16,
  parameter int PROBE_PRIME = 13
) (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              start,
  output      logic              busy,
  input  wire dht_pkg::dht_req_t req,
  output      logic              done,
  output      dht_pkg::dht_rsp_t rsp
);
  import dht_pkg::*;

  logic     accept;
  logic     front_active;
  logic     clearing;
  logic     push;
  logic     full;
  logic     pop;
  logic     empty;
  dht_job_t push_job;
  dht_job_t head;

  assign busy   = front_active || clearing;
  assign accept = start && !busy;

  dht_front #(
    .TABLE_SIZE  (TABLE_SIZE),
    .PROBE_PRIME (PROBE_PRIME)
  ) u_front (
    .clk    (clk),
    .rst    (rst),
    .accept (accept),
    .req    (req),
    .active (front_active),
    .push   (push),
    .job    (push_job),
    .full   (full)
  );

  dht_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .push_job (push_job),
    .full     (full),
    .pop      (pop),
    .head     (head),
    .empty    (empty)
  );

  dht_back #(
    .TABLE_SIZE  (TABLE_SIZE)
  ) u_back (
    .clk      (clk),
    .rst      (rst),
    .head     (head),
    .empty    (empty),
    .pop      (pop),
    .clearing (clearing),
    .done     (done),
    .rsp      (rsp)
  );

endmodule

`default_nettype wire

/* sv/dht_checker.sv */
// ============================================================================
// dht_checker
// Port-level checks of the key table core, bound to the top level.
// ============================================================================
`default_nettype none

module dht_checker (
  input wire logic              clk,
  input wire logic              rst,
  input wire logic              start,
  input wire logic              busy,
  input wire dht_pkg::dht_req_t req,
  input wire logic              done,
  input wire dht_pkg::dht_rsp_t rsp
);
  import dht_pkg::*;

  // Reset starts the clearing pass, during which nothing is taken or shown.
  a_reset_clears: assert property (@(posedge clk)
    rst |=> busy && !done)
    else $error("no clearing pass or stray result after reset");

  // A transfer in keeps the front end occupied on the next cycle.
  a_accept_busy: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |=> busy)
    else $error("busy low right after a request transfer");

  a_status_code: assert property (@(posedge clk) disable iff (rst)
    done |-> (rsp.status == ST_OK || rsp.status == ST_MISS || rsp.status == ST_ZERO))
    else $error("result with an undefined status code");

  a_fail_slot: assert property (@(posedge clk) disable iff (rst)
    (done && rsp.status != ST_OK) |-> rsp.slot_index == '0)
    else $error("failed request reports a nonzero slot");

endmodule

bind double_hash_table_core dht_checker u_dht_checker (
  .clk   (clk),
  .rst   (rst),
  .start (start),
  .busy  (busy),
  .req   (req),
  .done  (done),
  .rsp   (rsp)
);

`default_nettype wire

/* tb/double_hash_table_core_test.sv */
`timescale 1ns / 1ps
// ============================================================================
// double_hash_table_core_test
// Self-checking bench for the double hashing key table: requests are sent
// with random gaps, each transfer is mirrored in a local copy of the table,
// and every result strobe is compared with the oldest predicted answer.
// ============================================================================

module double_hash_table_core_test;

  import dht_pkg::*;

  localparam int TBL_SIZE    = 16;
  localparam int TBL_PRIME   = 13;
  localparam int TBL_IDX_W   = $clog2(TBL_SIZE);
  localparam int CYCLE_LIMIT = 300000;
  localparam int RANDOM_REQS = 1000;

  logic     clk;
  logic     rst   = 1'b1;
  logic     start = 1'b0;
  dht_req_t req   = '0;
  logic     busy;
  logic     done;
  dht_rsp_t rsp;

  logic [KEY_W-1:0] model_slots [TBL_SIZE];
  dht_rsp_t         awaited_rsp [$];
  logic [KEY_W-1:0] key_pool [$];
  dht_rsp_t         oldest;
  int               mismatches  = 0;
  int               cycle_count = 0;
  bit               idle_on     = 1'b1;

  double_hash_table_core #(
    .TABLE_SIZE (TBL_SIZE),
    .PROBE_PRIME(TBL_PRIME)
  ) u_dut (
    .clk  (clk),
    .rst  (rst),
    .start(start),
    .busy (busy),
    .req  (req),
    .done (done),
    .rsp  (rsp)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  // Walks the probe sequence of the local table copy and updates it on insert.
  function automatic dht_rsp_t probe_table(input logic fn, input logic [KEY_W-1:0] k);
    dht_rsp_t    r;
    int unsigned pos;
    int unsigned stride;
    r.slot_index = '0;
    r.status     = ST_MISS;
    if (k == '0) begin
      r.status = ST_ZERO;
      return r;
    end
    pos    = int'(k) % TBL_SIZE;
    stride = (TBL_PRIME - int'(k) % TBL_PRIME) % TBL_SIZE;
    for (int i = 0; i < TBL_SIZE; i++) begin
      if (fn == FN_INSERT) begin
        if (model_slots[pos[TBL_IDX_W-1:0]] == '0) begin
          model_slots[pos[TBL_IDX_W-1:0]] = k;
          r.slot_index     = pos[SLOT_W-1:0];
          r.status         = ST_OK;
          return r;
        end
      end else begin
        if (model_slots[pos[TBL_IDX_W-1:0]] == k) begin
          r.slot_index = pos[SLOT_W-1:0];
          r.status     = ST_OK;
          return r;
        end
        if (model_slots[pos[TBL_IDX_W-1:0]] == '0) break;
      end
      pos = (pos + stride) % TBL_SIZE;
    end
    return r;
  endfunction

  // Busy only moves at rising edges, so its value at the falling edge is the
  // one the next rising edge sees.
  task automatic send_req(input logic fn, input logic [KEY_W-1:0] k);
    int  gap;
    bit  taken;
    gap = idle_on ? $urandom_range(0, 14) : 0;
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    start <= 1'b1;
    req   <= dht_req_t'{func: fn, key: k};
    taken = 1'b0;
    while (!taken) begin
      @(negedge clk);
      taken = !busy;
      @(posedge clk);
    end
    awaited_rsp.push_back(probe_table(fn, k));
    if (k != '0) key_pool.push_back(k);
  endtask

  always @(negedge clk) begin
    if (!rst && done) begin
      if (awaited_rsp.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected result: slot %0d status %0d", rsp.slot_index, rsp.status);
      end else begin
        oldest = awaited_rsp.pop_front();
        if (rsp.slot_index !== oldest.slot_index || rsp.status !== oldest.status) begin
          mismatches++;
          if (mismatches <= 10)
            $display("result mismatch: expected slot %0d status %0d, got slot %0d status %0d",
                     oldest.slot_index, oldest.status, rsp.slot_index, rsp.status);
        end
      end
    end
  end

  task automatic test_zero_key;
    send_req(FN_INSERT, '0);
    send_req(FN_SEARCH, '0);
  endtask

  task automatic test_insert_search;
    send_req(FN_SEARCH, 31'd5);
    send_req(FN_INSERT, 31'h7FFF_FFFF);
    send_req(FN_SEARCH, 31'h7FFF_FFFF);
    send_req(FN_SEARCH, 31'h7FFF_FFFE);
    send_req(FN_INSERT, 31'd1);
    send_req(FN_SEARCH, 31'd1);
    // A key that is a multiple of the prime steps by the prime itself.
    send_req(FN_INSERT, 31'd13);
    send_req(FN_SEARCH, 31'd13);
  endtask

  task automatic test_duplicates;
    send_req(FN_INSERT, 31'd42);
    send_req(FN_INSERT, 31'd42);
    send_req(FN_SEARCH, 31'd42);
  endtask

  // These keys share a home slot and a step of 8, so they only ever visit two
  // slots: the third insert reports a miss and its search runs out of probes.
  task automatic test_short_cycle;
    send_req(FN_INSERT, 31'd83);
    send_req(FN_INSERT, 31'd291);
    send_req(FN_INSERT, 31'd499);
    send_req(FN_SEARCH, 31'd499);
    send_req(FN_SEARCH, 31'd291);
  endtask

  task automatic test_random_mix;
    logic [KEY_W-1:0] k;
    logic             fn;
    int               pick;
    for (int n = 0; n < RANDOM_REQS; n++) begin
      if (n % 50 == 0) idle_on = ($urandom_range(0, 3) != 0);
      pick = $urandom_range(0, 19);
      if (pick == 0)
        k = '0;
      else if (pick == 1)
        k = 31'h7FFF_FFFF;
      else if (pick < 8)
        k = KEY_W'($urandom());
      else if (pick < 14 && key_pool.size() > 0)
        k = key_pool[$urandom_range(0, key_pool.size() - 1)];
      else
        k = KEY_W'($urandom_range(1, 600));
      fn = ($urandom_range(0, 9) < 4) ? FN_INSERT : FN_SEARCH;
      send_req(fn, k);
    end
  endtask

  initial begin
    foreach (model_slots[i]) model_slots[i] = '0;
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    test_zero_key();
    test_insert_search();
    test_duplicates();
    test_short_cycle();
    test_random_mix();
    start <= 1'b0;
    while (awaited_rsp.size() != 0) @(posedge clk);
    repeat (40) @(posedge clk);
    if (mismatches == 0 && awaited_rsp.size() == 0)
      $display("SCOREBOARD CLEAN");
    else
      $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule
